[sv/mrcc_pkg.sv]
// Shared types, constants and field helpers for the mask row/column centreline block.
// No dependencies; every other file of the block but mrcc_ram imports this package.
package mrcc_pkg;

   localparam int DEFAULT_MAX_COLS = 4096;
   localparam int DEFAULT_MAX_ROWS = 4096;

   localparam int FIELD_W     = 12;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 13;

   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_WIDTH  = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_HEIGHT = 1'd1;

   localparam logic [CSR_DATA_W-1:0] RESET_IMAGE_WIDTH  = 13'd1024;
   localparam logic [CSR_DATA_W-1:0] RESET_IMAGE_HEIGHT = 13'd1024;

   localparam logic RESULT_ROW    = 1'b0;
   localparam logic RESULT_COLUMN = 1'b1;

   typedef struct packed {
      logic pixel_valid;
   } req_payload_type;

   typedef struct packed {
      logic               result_kind;
      logic [FIELD_W-1:0] line_index;
      logic [FIELD_W-1:0] center;
      logic [FIELD_W-1:0] extent;
      logic               run_last;
      logic               image_done;
   } rsp_payload_type;

   // Per-pixel control flags handed from the scan counters to the column stage.
   typedef struct packed {
      logic pixel;
      logic row_end;
      logic last_row;
      logic first_row;
   } item_flags_type;

   // Up to two results caused by one pixel, in delivery order.
   typedef struct packed {
      rsp_payload_type first;
      rsp_payload_type second;
      logic [1:0]      count;
   } result_pair_type;

   function automatic logic [FIELD_W-1:0] field_of(input logic [31:0] value);
      return value[FIELD_W-1:0];
   endfunction

   function automatic logic [FIELD_W-1:0] mid_field(input logic [31:0] least,
                                                    input logic [31:0] greatest);
      logic [31:0] sum;
      sum = (least + greatest) >> 1;
      return sum[FIELD_W-1:0];
   endfunction

   function automatic logic [FIELD_W-1:0] span_field(input logic [31:0] least,
                                                     input logic [31:0] greatest);
      logic [31:0] diff;
      diff = (greatest > least) ? (greatest - least) : 32'd0;
      return diff[FIELD_W-1:0];
   endfunction

endpackage

[sv/mrcc_chan_if.sv]
// Valid/ready channel carrying one word of a payload type per handshake.
// Depends on mrcc_pkg for the default payload type.
interface mrcc_chan_if import mrcc_pkg::*; #(parameter type payload_type = req_payload_type) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

[sv/mask_row_column_centerlines.sv]
// Channel   Direction  Word                     Handshake
// req_chan  in         pixel_valid              valid/ready, taken when both high
// rsp_chan  out        kind, index, centre, ... valid/ready, taken when both high
// csr_*     in         index, 13-bit data       write on csr_we, no read-back
//
// One pixel is taken every clock unless the column stage waits for room in the output
// buffer. A result passes through the column stage, whose RAM read is registered, then
// the output buffer. On the last row a row-end pixel gives two words, which the single
// result port sends in turn. Reset is synchronous and clears the control state;
// the column RAM needs no clearing because the first row writes every entry before it
// is read. A stall on rsp_chan backs up through the buffer and the column stage.
module mask_row_column_centerlines import mrcc_pkg::*; #(
   parameter int MAX_COLS = DEFAULT_MAX_COLS,
   parameter int MAX_ROWS = DEFAULT_MAX_ROWS,
   localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1,
   localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   mrcc_chan_if.sink              req_chan,
   mrcc_chan_if.source            rsp_chan
);

   logic            accept;
   logic            item_ready;
   item_flags_type  flags;
   logic [CW-1:0]   col;
   logic [RW-1:0]   row;
   logic [CW:0]     row_least;
   logic [CW-1:0]   row_greatest;
   logic [RW:0]     eff_height;
   logic            ob_free;
   logic            load;
   result_pair_type pair;

   mrcc_scan #(
      .MAX_COLS (MAX_COLS),
      .MAX_ROWS (MAX_ROWS)
   ) u_scan (
      .clock        (clock),
      .reset        (reset),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .req_chan     (req_chan),
      .item_ready   (item_ready),
      .accept       (accept),
      .flags        (flags),
      .col          (col),
      .row          (row),
      .row_least    (row_least),
      .row_greatest (row_greatest),
      .eff_height   (eff_height)
   );

   mrcc_colstage #(
      .MAX_COLS (MAX_COLS),
      .MAX_ROWS (MAX_ROWS)
   ) u_colstage (
      .clock           (clock),
      .reset           (reset),
      .accept          (accept),
      .flags_in        (flags),
      .col_in          (col),
      .row_in          (row),
      .row_least_in    (row_least),
      .row_greatest_in (row_greatest),
      .eff_height      (eff_height),
      .ob_free         (ob_free),
      .item_ready      (item_ready),
      .load            (load),
      .pair            (pair)
   );

   mrcc_outbuf u_outbuf (
      .clock    (clock),
      .reset    (reset),
      .load     (load),
      .pair     (pair),
      .ob_free  (ob_free),
      .rsp_chan (rsp_chan)
   );

endmodule

[sv/mrcc_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; a read at the address being written returns the old contents.
module mrcc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic             re,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

[sv/mrcc_scan.sv]
// Image geometry registers, raster position counters and the row min/max tracker.
// Depends on mrcc_pkg and mrcc_chan_if.
module mrcc_scan import mrcc_pkg::*; #(
   parameter int MAX_COLS = DEFAULT_MAX_COLS,
   parameter int MAX_ROWS = DEFAULT_MAX_ROWS,
   localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1,
   localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   mrcc_chan_if.sink              req_chan,
   input  logic                   item_ready,
   output logic                   accept,
   output item_flags_type         flags,
   output logic [CW-1:0]          col,
   output logic [RW-1:0]          row,
   output logic [CW:0]            row_least,
   output logic [CW-1:0]          row_greatest,
   output logic [RW:0]            eff_height
);

   logic [CSR_DATA_W-1:0] width_ff, width_in;
   logic [CSR_DATA_W-1:0] height_ff, height_in;
   logic [CW-1:0]         col_ff, col_in;
   logic [RW-1:0]         row_ff, row_in;
   logic [CW:0]           rl_ff, rl_in;
   logic [CW-1:0]         rg_ff, rg_in;
   logic                  fresh_ff, fresh_in;

   logic [CW:0]   w_eff;
   logic [RW:0]   h_eff;
   logic [CW:0]   rl_cur, rl_upd;
   logic [CW-1:0] rg_cur, rg_upd;
   logic          pix, row_end, last_row;

   // A size of zero counts as one; a size beyond the store depth is clamped to it.
   always_comb begin
      if (width_ff == '0) begin
         w_eff = (CW+1)'(1);
      end else if (32'(width_ff) > 32'(MAX_COLS)) begin
         w_eff = (CW+1)'(MAX_COLS);
      end else begin
         w_eff = (CW+1)'(width_ff);
      end
      if (height_ff == '0) begin
         h_eff = (RW+1)'(1);
      end else if (32'(height_ff) > 32'(MAX_ROWS)) begin
         h_eff = (RW+1)'(MAX_ROWS);
      end else begin
         h_eff = (RW+1)'(height_ff);
      end
   end

   assign pix      = req_chan.payload.pixel_valid;
   assign row_end  = ((CW+1)'(col_ff) + (CW+1)'(1)) == w_eff;
   assign last_row = ((RW+1)'(row_ff) + (RW+1)'(1)) == h_eff;
   assign accept   = req_chan.valid && item_ready;
   assign req_chan.ready = item_ready;

   // The fresh flag stands for an empty row: least reads as the width and greatest as zero.
   assign rl_cur = fresh_ff ? w_eff : rl_ff;
   assign rg_cur = fresh_ff ? '0 : rg_ff;
   assign rl_upd = (pix && ((CW+1)'(col_ff) < rl_cur)) ? (CW+1)'(col_ff) : rl_cur;
   assign rg_upd = (pix && (col_ff > rg_cur)) ? col_ff : rg_cur;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      col_in    = col_ff;
      row_in    = row_ff;
      rl_in     = rl_ff;
      rg_in     = rg_ff;
      fresh_in  = fresh_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_IMAGE_WIDTH: begin
               width_in = csr_wdata;
            end
            CSR_IMAGE_HEIGHT: begin
               height_in = csr_wdata;
            end
            default: begin
            end
         endcase
         col_in   = '0;
         row_in   = '0;
         fresh_in = 1'b1;
      end else if (accept) begin
         if (row_end) begin
            col_in   = '0;
            row_in   = last_row ? '0 : row_ff + RW'(1);
            fresh_in = 1'b1;
         end else begin
            col_in   = col_ff + CW'(1);
            rl_in    = rl_upd;
            rg_in    = rg_upd;
            fresh_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= RESET_IMAGE_WIDTH;
         height_ff <= RESET_IMAGE_HEIGHT;
         col_ff    <= '0;
         row_ff    <= '0;
         fresh_ff  <= 1'b1;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         col_ff    <= col_in;
         row_ff    <= row_in;
         fresh_ff  <= fresh_in;
      end
      rl_ff <= rl_in;
      rg_ff <= rg_in;
   end

   assign flags.pixel     = pix;
   assign flags.row_end   = row_end;
   assign flags.last_row  = last_row;
   assign flags.first_row = (row_ff == '0);
   assign col          = col_ff;
   assign row          = row_ff;
   assign row_least    = rl_upd;
   assign row_greatest = rg_upd;
   assign eff_height   = h_eff;

   a_col_in_range: assert property (@(posedge clock) disable iff (reset)
      (CW+1)'(col_ff) < w_eff)
      else $error("column counter outside the image width");

   a_image_wrap: assert property (@(posedge clock) disable iff (reset)
      accept && row_end && last_row && !csr_we |=> (row_ff == '0) && (col_ff == '0))
      else $error("raster position did not wrap after the final pixel");

endmodule

[sv/mrcc_colstage.sv]
// Column stage: holds one pixel, updates its column's min/max in the column RAM
// and forms the column and row results. Depends on mrcc_pkg and mrcc_ram.
module mrcc_colstage import mrcc_pkg::*; #(
   parameter int MAX_COLS = DEFAULT_MAX_COLS,
   parameter int MAX_ROWS = DEFAULT_MAX_ROWS,
   localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1,
   localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            accept,
   input  item_flags_type  flags_in,
   input  logic [CW-1:0]   col_in,
   input  logic [RW-1:0]   row_in,
   input  logic [CW:0]     row_least_in,
   input  logic [CW-1:0]   row_greatest_in,
   input  logic [RW:0]     eff_height,
   input  logic            ob_free,
   output logic            item_ready,
   output logic            load,
   output result_pair_type pair
);

   localparam int DW = 2 * RW + 1;

   logic           s1_v_ff, s1_v_in;
   item_flags_type s1_flags_ff;
   logic [CW-1:0]  s1_col_ff;
   logic [RW-1:0]  s1_row_ff;
   logic [CW:0]    s1_rl_ff;
   logic [CW-1:0]  s1_rg_ff;
   logic           fwd_ff;
   logic [RW:0]    fwd_least_ff;
   logic [RW-1:0]  fwd_greatest_ff;

   logic [DW-1:0]   ram_rdata;
   logic [RW:0]     base_least, cl;
   logic [RW-1:0]   base_greatest, cg;
   logic            s1_fire;
   rsp_payload_type col_res, row_res;
   logic [1:0]      n_res;

   mrcc_ram #(
      .WIDTH (DW),
      .DEPTH (MAX_COLS)
   ) u_column_ram (
      .clock (clock),
      .we    (s1_fire),
      .waddr (s1_col_ff),
      .wdata ({cl, cg}),
      .re    (accept),
      .raddr (col_in),
      .rdata (ram_rdata)
   );

   // The first row starts every column afresh. When the pixel ahead wrote the same
   // column in the cycle of the read, the RAM returns stale data and the written
   // word is taken instead.
   always_comb begin
      if (s1_flags_ff.first_row) begin
         base_least    = eff_height;
         base_greatest = '0;
      end else if (fwd_ff) begin
         base_least    = fwd_least_ff;
         base_greatest = fwd_greatest_ff;
      end else begin
         base_least    = ram_rdata[DW-1:RW];
         base_greatest = ram_rdata[RW-1:0];
      end
      cl = (s1_flags_ff.pixel && ((RW+1)'(s1_row_ff) < base_least)) ?
           (RW+1)'(s1_row_ff) : base_least;
      cg = (s1_flags_ff.pixel && (s1_row_ff > base_greatest)) ? s1_row_ff : base_greatest;
   end

   always_comb begin
      col_res.result_kind = RESULT_COLUMN;
      col_res.line_index  = field_of(32'(s1_col_ff));
      col_res.center      = mid_field(32'(cl), 32'(cg));
      col_res.extent      = span_field(32'(cl), 32'(cg));
      col_res.run_last    = 1'b0;
      col_res.image_done  = 1'b0;

      row_res.result_kind = RESULT_ROW;
      row_res.line_index  = field_of(32'(s1_row_ff));
      row_res.center      = mid_field(32'(s1_rl_ff), 32'(s1_rg_ff));
      row_res.extent      = span_field(32'(s1_rl_ff), 32'(s1_rg_ff));
      row_res.run_last    = 1'b0;
      row_res.image_done  = 1'b0;

      n_res = 2'(s1_flags_ff.last_row) + 2'(s1_flags_ff.row_end);

      pair.first  = s1_flags_ff.last_row ? col_res : row_res;
      pair.second = row_res;
      pair.count  = n_res;
      if (n_res == 2'd2) begin
         pair.second.run_last   = 1'b1;
         pair.second.image_done = 1'b1;
      end else begin
         pair.first.run_last = 1'b1;
      end
   end

   // A pixel that causes no result leaves the stage without waiting for the buffer.
   assign s1_fire    = s1_v_ff && ((n_res == 2'd0) || ob_free);
   assign item_ready = !s1_v_ff || s1_fire;
   assign load       = s1_fire && (n_res != 2'd0);

   always_comb begin
      s1_v_in = s1_v_ff;
      if (accept) begin
         s1_v_in = 1'b1;
      end else if (s1_fire) begin
         s1_v_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
      end else begin
         s1_v_ff <= s1_v_in;
      end
      if (accept) begin
         s1_flags_ff     <= flags_in;
         s1_col_ff       <= col_in;
         s1_row_ff       <= row_in;
         s1_rl_ff        <= row_least_in;
         s1_rg_ff        <= row_greatest_in;
         fwd_ff          <= s1_fire && (col_in == s1_col_ff);
         fwd_least_ff    <= cl;
         fwd_greatest_ff <= cg;
      end
   end

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      s1_v_ff && !s1_fire |=> s1_v_ff && $stable(s1_col_ff) && $stable(s1_row_ff))
      else $error("column stage lost or changed a stalled pixel");

endmodule

[sv/mrcc_outbuf.sv]
// Two-word result buffer that parts the column stage from the result channel.
// Depends on mrcc_pkg and mrcc_chan_if.
module mrcc_outbuf import mrcc_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            load,
   input  result_pair_type pair,
   output logic            ob_free,
   mrcc_chan_if.source     rsp_chan
);

   rsp_payload_type slot0_ff, slot0_in;
   rsp_payload_type slot1_ff, slot1_in;
   logic [1:0]      cnt_ff, cnt_in;
   logic            fire;

   assign rsp_chan.valid   = (cnt_ff != 2'd0);
   assign rsp_chan.payload = slot0_ff;
   assign fire    = rsp_chan.valid && rsp_chan.ready;
   assign ob_free = (cnt_ff == 2'd0) || ((cnt_ff == 2'd1) && fire);

   always_comb begin
      slot0_in = slot0_ff;
      slot1_in = slot1_ff;
      cnt_in   = cnt_ff;
      if (load) begin
         slot0_in = pair.first;
         slot1_in = pair.second;
         cnt_in   = pair.count;
      end else if (fire) begin
         slot0_in = slot1_ff;
         cnt_in   = cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
   end

   a_done_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.payload.image_done |-> rsp_chan.payload.run_last)
      else $error("image_done set on a word that does not close its pixel");

   a_pair_order: assert property (@(posedge clock) disable iff (reset)
      cnt_ff == 2'd2 |-> !slot0_ff.run_last && slot1_ff.run_last)
      else $error("first of two buffered words marked as the pixel's last");

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 1ps
// Testbench for mask_row_column_centerlines: streams pixel words, predicts every row and
// column centreline word and checks what the block returns. Needs mrcc_pkg, mrcc_chan_if.
module testbench;
   import mrcc_pkg::*;

   localparam int QUIET_LIMIT   = 2000;
   localparam int SETTLE_CYCLES = 20;
   localparam int RANDOM_PIXELS = 400;
   localparam int EXTREME_PIXELS = 48;
   localparam int NUM_COLS      = DEFAULT_MAX_COLS;
   localparam int NUM_ROWS      = DEFAULT_MAX_ROWS;

   typedef enum int {FILL_EMPTY, FILL_FULL, FILL_HALF, FILL_SPARSE} fill_kind_type;

   logic                   clock;
   logic                   reset;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   mrcc_chan_if #(.payload_type(req_payload_type)) req_if ();
   mrcc_chan_if #(.payload_type(rsp_payload_type)) rsp_if ();

   mask_row_column_centerlines uut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_chan  (req_if),
      .rsp_chan  (rsp_if)
   );

   // Predicted state of the scan and of the per-column trackers.
   logic [CSR_DATA_W-1:0] size_cols;
   logic [CSR_DATA_W-1:0] size_rows;
   int unsigned           scan_col;
   int unsigned           scan_row;
   int unsigned           row_lo;
   int unsigned           row_hi;
   int unsigned           col_lo [NUM_COLS];
   int unsigned           col_hi [NUM_COLS];
   rsp_payload_type       pending_lines [$];

   int mismatch_count;
   int quiet_cycles;
   int random_sent;
   bit no_idle;

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   function automatic int unsigned active_cols();
      int unsigned n;
      n = 32'(size_cols);
      if (n == 0) n = 1;
      if (n > NUM_COLS) n = NUM_COLS;
      return n;
   endfunction

   function automatic int unsigned active_rows();
      int unsigned n;
      n = 32'(size_rows);
      if (n == 0) n = 1;
      if (n > NUM_ROWS) n = NUM_ROWS;
      return n;
   endfunction

   function automatic void restart_scan();
      scan_col = 0;
      scan_row = 0;
      row_lo   = active_cols();
      row_hi   = 0;
   endfunction

   function automatic rsp_payload_type line_word(logic kind, int unsigned idx,
                                                 int unsigned lo, int unsigned hi);
      rsp_payload_type word;
      int unsigned     mid;
      int unsigned     span;
      mid  = (lo + hi) / 2;
      span = (hi > lo) ? hi - lo : 0;
      word = '0;
      word.result_kind = kind;
      word.line_index  = idx[FIELD_W-1:0];
      word.center      = mid[FIELD_W-1:0];
      word.extent      = span[FIELD_W-1:0];
      return word;
   endfunction

   function automatic void predict_pixel(logic pix);
      int unsigned     w;
      int unsigned     h;
      int unsigned     c;
      int unsigned     r;
      int unsigned     lo;
      int unsigned     hi;
      bit              row_end;
      bit              last_row;
      rsp_payload_type words [2];
      int              n;
      w = active_cols();
      h = active_rows();
      c = (scan_col >= w) ? w - 1 : scan_col;
      r = (scan_row >= h) ? h - 1 : scan_row;
      row_end  = (c == w - 1);
      last_row = (r == h - 1);
      n = 0;
      if (pix) begin
         if (c < row_lo) row_lo = c;
         if (c > row_hi) row_hi = c;
      end
      // The first row of an image loads each column tracker afresh.
      if (r == 0) begin
         lo = h;
         hi = 0;
      end else begin
         lo = col_lo[c];
         hi = col_hi[c];
      end
      if (pix) begin
         if (r < lo) lo = r;
         if (r > hi) hi = r;
      end
      col_lo[c] = lo;
      col_hi[c] = hi;
      if (last_row) begin
         words[n] = line_word(RESULT_COLUMN, c, lo, hi);
         n++;
      end
      if (row_end) begin
         words[n] = line_word(RESULT_ROW, r, row_lo, row_hi);
         n++;
      end
      if (n > 0) begin
         words[n-1].run_last   = 1'b1;
         words[n-1].image_done = row_end && last_row;
      end
      for (int i = 0; i < n; i++) pending_lines.push_back(words[i]);
      if (row_end) begin
         row_lo   = w;
         row_hi   = 0;
         scan_col = 0;
         scan_row = last_row ? 0 : r + 1;
      end else begin
         scan_col = c + 1;
         scan_row = r;
      end
   endfunction

   function automatic void check_field(string tag, logic [FIELD_W-1:0] want,
                                       logic [FIELD_W-1:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %0d got %0d", $time, tag, want, got);
         mismatch_count++;
      end
   endfunction

   // Result side: random back-pressure unless a stretch without idling is running.
   always @(negedge clock) begin
      rsp_if.ready <= no_idle || ($urandom_range(99) >= 16);
   end

   always @(posedge clock) begin
      rsp_payload_type want;
      if (!reset && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
         if (pending_lines.size() == 0) begin
            $display("%0t: unexpected word, expected none got %h", $time, rsp_if.payload);
            mismatch_count++;
         end else begin
            want = pending_lines.pop_front();
            check_field("result_kind", FIELD_W'(want.result_kind),
                        FIELD_W'(rsp_if.payload.result_kind));
            check_field("line_index", want.line_index, rsp_if.payload.line_index);
            check_field("center", want.center, rsp_if.payload.center);
            check_field("extent", want.extent, rsp_if.payload.extent);
            check_field("run_last", FIELD_W'(want.run_last),
                        FIELD_W'(rsp_if.payload.run_last));
            check_field("image_done", FIELD_W'(want.image_done),
                        FIELD_W'(rsp_if.payload.image_done));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || csr_we === 1'b1 || (req_if.valid === 1'b1 && req_if.ready === 1'b1) ||
          (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("testbench: FAIL");
         $finish;
      end
   end

   task automatic send_pixel(input logic pix);
      @(negedge clock);
      while (!no_idle && $urandom_range(99) < 16) begin
         req_if.valid <= 1'b0;
         @(negedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.payload.pixel_valid <= pix;
      do @(posedge clock); while (req_if.ready !== 1'b1);
      predict_pixel(pix);
   endtask

   function automatic logic pick_pixel(fill_kind_type fill);
      case (fill)
         FILL_EMPTY: return 1'b0;
         FILL_FULL:  return 1'b1;
         FILL_HALF:  return 1'($urandom_range(1));
         default:    return ($urandom_range(7) == 0);
      endcase
   endfunction

   task automatic send_pixels(input int unsigned count, input fill_kind_type fill);
      for (int unsigned i = 0; i < count; i++) send_pixel(pick_pixel(fill));
   endtask

   // Lowers valid, waits for every expected word and lets a pixel with no word drain.
   task automatic settle_block();
      @(negedge clock);
      req_if.valid <= 1'b0;
      while (pending_lines.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_INDEX_W-1:0] idx,
                                 input int unsigned value);
      settle_block();
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value[CSR_DATA_W-1:0];
      @(negedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_IMAGE_WIDTH)
         size_cols = value[CSR_DATA_W-1:0];
      else
         size_rows = value[CSR_DATA_W-1:0];
      restart_scan();
   endtask

   task automatic set_size(input int unsigned cols, input int unsigned rows);
      write_register(CSR_IMAGE_WIDTH, cols);
      write_register(CSR_IMAGE_HEIGHT, rows);
   endtask

   function automatic int unsigned pick_size(int unsigned limit);
      int unsigned roll;
      roll = $urandom_range(19);
      if (roll == 0) return 0;
      if (roll == 1) return $urandom_range(3 * limit, limit + 1);
      return $urandom_range(limit, 1);
   endfunction

   task automatic test_corner_images();
      // A few words at the reset size, cut short by the next register write.
      send_pixel(1'b1);
      send_pixel(1'b0);
      send_pixel(1'b1);
      // Zero sizes act as one, so every pixel closes the whole image.
      set_size(0, 0);
      send_pixel(1'b1);
      send_pixel(1'b0);
      set_size(3, 2);
      send_pixel(1'b0);
      send_pixel(1'b1);
      send_pixel(1'b0);
      send_pixel(1'b1);
      send_pixel(1'b0);
      send_pixel(1'b1);
      send_pixels(6, FILL_EMPTY);
      send_pixels(6, FILL_FULL);
   endtask

   task automatic test_size_extremes();
      // Sizes above the maximum are clamped; a one-row image gives a column word per pixel.
      set_size(8191, 1);
      send_pixels(EXTREME_PIXELS, FILL_HALF);
      set_size(1, 8191);
      send_pixels(EXTREME_PIXELS, FILL_HALF);
   endtask

   task automatic test_back_to_back();
      no_idle = 1'b1;
      set_size(9, 4);
      send_pixels(9 * 4 * 3, FILL_HALF);
      settle_block();
      no_idle = 1'b0;
   endtask

   task automatic test_random_images();
      int unsigned   cols;
      int unsigned   rows;
      int unsigned   total;
      fill_kind_type fill;
      bit            first;
      first = 1'b1;
      random_sent = 0;
      while (random_sent < RANDOM_PIXELS) begin
         cols = pick_size(12);
         rows = pick_size(6);
         if (first) begin
            set_size(cols, rows);
            first = 1'b0;
         end else begin
            case ($urandom_range(2))
               0:       write_register(CSR_IMAGE_WIDTH, cols);
               1:       write_register(CSR_IMAGE_HEIGHT, rows);
               default: set_size(cols, rows);
            endcase
         end
         fill  = fill_kind_type'($urandom_range(3));
         total = active_cols() * active_rows() * $urandom_range(3, 1);
         // Some phases stop part way through an image.
         if ($urandom_range(99) < 15) total = $urandom_range(total, 1);
         if (total > RANDOM_PIXELS - random_sent) total = RANDOM_PIXELS - random_sent;
         send_pixels(total, fill);
         random_sent += total;
      end
   endtask

   initial begin
      reset          = 1'b1;
      csr_we         = 1'b0;
      csr_index      = CSR_IMAGE_WIDTH;
      csr_wdata      = '0;
      req_if.valid   = 1'b0;
      req_if.payload = '0;
      rsp_if.ready   = 1'b0;
      mismatch_count = 0;
      quiet_cycles   = 0;
      random_sent    = 0;
      no_idle        = 1'b0;
      size_cols      = RESET_IMAGE_WIDTH;
      size_rows      = RESET_IMAGE_HEIGHT;
      restart_scan();
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_corner_images();
      test_size_extremes();
      test_back_to_back();
      test_random_images();
      settle_block();

      if (mismatch_count == 0 && pending_lines.size() == 0)
         $display("testbench: PASS");
      else
         $display("testbench: FAIL");
      $finish;
   end

endmodule

[filelist.f]
sv/mrcc_pkg.sv
sv/mrcc_chan_if.sv
sv/mrcc_ram.sv
sv/mrcc_scan.sv
sv/mrcc_colstage.sv
sv/mrcc_outbuf.sv
sv/mask_row_column_centerlines.sv
tb/sv/testbench.sv
